[src/rgbw_pkg.sv]
// ----------------------------------------------------------------------------
// rgbw_pkg
// Shared types and constants for the RGBW LED duty-code frame encoder.
// ----------------------------------------------------------------------------
package rgbw_pkg;

    // Store depth default and fixed field widths
    localparam int PIXEL_COUNT_DEF = 6;
    localparam int CODES_PER_PIXEL = 32;
    localparam int CNT_W           = $clog2(CODES_PER_PIXEL);
    localparam int SLOT_W          = 4;
    localparam int IDX_FIELD_W     = 3;
    localparam int BYTE_W          = 8;
    localparam int WORD_W          = 4 * BYTE_W;
    localparam int CFG_IDX_W       = 2;

    // Register reset values
    localparam logic [BYTE_W-1:0] DUTY_ONE_RST  = 8'd38;
    localparam logic [BYTE_W-1:0] DUTY_ZERO_RST = 8'd19;

    // Command codes
    typedef enum logic [1:0] {
        CMD_SET_ONE = 2'd0,
        CMD_SET_ALL = 2'd1,
        CMD_RENDER  = 2'd2,
        CMD_REFILL  = 2'd3
    } t_cmd;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DUTY_ONE  = 2'd0,
        CFG_DUTY_ZERO = 2'd1
    } t_cfg_idx;

    // One input beat
    typedef struct packed {
        t_cmd                   command;
        logic [IDX_FIELD_W-1:0] pixel_index;
        logic [BYTE_W-1:0]      red;
        logic [BYTE_W-1:0]      green;
        logic [BYTE_W-1:0]      blue;
        logic [BYTE_W-1:0]      white;
    } t_in;

    // One output beat
    typedef struct packed {
        logic [BYTE_W-1:0] duty_code;
        logic              last_of_run;
        logic              frame_done;
    } t_out;

endpackage

[src/rgbw_led_duty_frame_encoder.sv]
// ----------------------------------------------------------------------------
// rgbw_led_duty_frame_encoder
// Pixel store and duty-code serializer for a string of RGBW addressable LEDs.
// ----------------------------------------------------------------------------
//
//  channel   direction  signals                                   handshake
//  --------  ---------  ----------------------------------------  -----------
//  input     in         i_in_valid, i_in_data, o_in_stall          valid/stall
//  output    out        o_out_valid, o_out_data, i_out_stall       valid/stall
//  config    in         i_cfg_valid, i_cfg_index, i_cfg_data,      valid/ready
//                       o_cfg_ready
//
//  Pixel commands and refills that emit nothing leave the serializer idle. A
//  render or a refill that emits codes holds the input while the serializer
//  sends one code per cycle unless the output stalls; the next beat is taken
//  in the cycle of the 32nd code. A stall on the output freezes the
//  serializer, which then stalls the input. Synchronous active-low reset
//  clears the store, the frame state and the duty registers to 38 and 19.

module rgbw_led_duty_frame_encoder #(
    parameter int PIXEL_COUNT = rgbw_pkg::PIXEL_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    input  rgbw_pkg::t_in                  i_in_data,
    output logic                           o_in_stall,
    // output channel
    output logic                           o_out_valid,
    output rgbw_pkg::t_out                 o_out_data,
    input  logic                           i_out_stall,
    // configuration channel
    input  logic                           i_cfg_valid,
    input  logic [rgbw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rgbw_pkg::BYTE_W-1:0]    i_cfg_data,
    output logic                           o_cfg_ready
);

    localparam int IDX_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int CNT_W = rgbw_pkg::CNT_W;
    localparam int SLOT_W = rgbw_pkg::SLOT_W;
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(rgbw_pkg::CODES_PER_PIXEL - 1);
    localparam logic [SLOT_W-1:0] SLOT_N   = SLOT_W'(PIXEL_COUNT);
    localparam logic [SLOT_W:0]   SLOT_END = (SLOT_W + 1)'(PIXEL_COUNT + 2);

    // State
    logic [rgbw_pkg::WORD_W-1:0] r_store [PIXEL_COUNT];
    logic [SLOT_W-1:0]           r_slot;
    logic                        r_active;
    logic [rgbw_pkg::BYTE_W-1:0] r_duty_one;
    logic [rgbw_pkg::BYTE_W-1:0] r_duty_zero;

    // Serializer
    logic                        r_busy;
    logic [CNT_W-1:0]            r_cnt;
    logic [rgbw_pkg::WORD_W-1:0] r_bits;
    logic                        r_is_reset;
    logic                        r_done;

    // Output register
    logic                        r_out_valid;
    rgbw_pkg::t_out              r_out_data;

    // Decoded input beat
    logic                        in_fire;
    logic                        adv;
    logic                        last_adv;
    logic [rgbw_pkg::WORD_W-1:0] in_word;
    logic [SLOT_W-1:0]           idx_ext;
    logic                        idx_ok;
    logic [IDX_W-1:0]            rd_idx;
    logic [rgbw_pkg::WORD_W-1:0] rd_word;
    logic [SLOT_W:0]             slot_next;
    logic                        start_emit;
    logic                        start_reset;
    logic                        start_done;
    logic [SLOT_W-1:0]           n_slot;
    logic                        n_active;
    rgbw_pkg::t_out              code;

    // Advance the serializer when the output register is free or draining
    assign adv      = r_busy && (!r_out_valid || !i_out_stall);
    assign last_adv = adv && (r_cnt == CNT_LAST);
    assign o_in_stall = r_busy && !last_adv;
    assign in_fire  = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Pack the pixel word as G,R,B,W
    assign in_word = {i_in_data.green, i_in_data.red, i_in_data.blue, i_in_data.white};
    assign idx_ext = SLOT_W'(i_in_data.pixel_index);
    assign idx_ok  = idx_ext < SLOT_N;

    // Read port: pixel 0 on render, else the current slot
    assign rd_idx  = (i_in_data.command == rgbw_pkg::CMD_RENDER) ? '0 : r_slot[IDX_W-1:0];
    assign rd_word = r_store[rd_idx];
    assign slot_next = {1'b0, r_slot} + (SLOT_W + 1)'(1);

    // Decide what the accepted beat does to the frame
    always_comb begin
        start_emit  = 1'b0;
        start_reset = 1'b0;
        start_done  = 1'b0;
        n_slot      = r_slot;
        n_active    = r_active;
        unique case (i_in_data.command)
            rgbw_pkg::CMD_RENDER: begin
                start_emit = 1'b1;
                n_active   = 1'b1;
                n_slot     = SLOT_W'(1);
            end
            rgbw_pkg::CMD_REFILL: begin
                if (r_active) begin
                    if (r_slot < SLOT_N) begin
                        start_emit = 1'b1;
                        n_slot     = slot_next[SLOT_W-1:0];
                    end else if (r_slot == SLOT_N) begin
                        n_slot = slot_next[SLOT_W-1:0];
                    end else begin
                        start_reset = 1'b1;
                        if (slot_next >= SLOT_END) begin
                            start_done = 1'b1;
                            n_slot     = '0;
                            n_active   = 1'b0;
                        end else begin
                            n_slot = slot_next[SLOT_W-1:0];
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Build the code for the current serializer position
    always_comb begin
        code.duty_code   = r_is_reset ? '0 : (r_bits[rgbw_pkg::WORD_W-1] ? r_duty_one
                                                                          : r_duty_zero);
        code.last_of_run = (r_cnt == CNT_LAST);
        code.frame_done  = r_done;
    end

    // Pixel store: single or broadcast write
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < PIXEL_COUNT; i++) begin
            if (!i_rst_n) begin
                r_store[i] <= '0;
            end else if (in_fire) begin
                if (i_in_data.command == rgbw_pkg::CMD_SET_ALL ||
                    (i_in_data.command == rgbw_pkg::CMD_SET_ONE && idx_ok &&
                     idx_ext == SLOT_W'(i))) begin
                    r_store[i] <= in_word;
                end
            end
        end
    end

    // Frame state and duty registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_active    <= 1'b0;
            r_duty_one  <= rgbw_pkg::DUTY_ONE_RST;
            r_duty_zero <= rgbw_pkg::DUTY_ZERO_RST;
        end else begin
            if (in_fire) begin
                r_slot   <= n_slot;
                r_active <= n_active;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    rgbw_pkg::CFG_DUTY_ONE:  r_duty_one  <= i_cfg_data;
                    rgbw_pkg::CFG_DUTY_ZERO: r_duty_zero <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Serializer control: load on a starting beat, advance one code per cycle unless stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (in_fire && (start_emit || start_reset)) begin
            r_busy <= 1'b1;
        end else if (last_adv) begin
            r_busy <= 1'b0;
        end
    end

    // Serializer payload
    always_ff @(posedge i_clk) begin
        if (in_fire && (start_emit || start_reset)) begin
            r_cnt      <= '0;
            r_bits     <= start_emit ? rd_word : '0;
            r_is_reset <= start_reset;
            r_done     <= start_done;
        end else if (adv) begin
            r_cnt  <= r_cnt + CNT_W'(1);
            r_bits <= r_bits << 1;
        end
    end

    // Output register: load on advance, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= code;
        end
    end

endmodule
